FILE: design/debug_packet_deframer_top_macros.svh
// Assertion macros for the debug packet deframer.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef DEBUG_PACKET_DEFRAMER_TOP_MACROS_SVH
`define DEBUG_PACKET_DEFRAMER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define DPD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("deframer check failed");

// Check a property on every clock edge, reset included.
`define DPD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("deframer check failed");

`else

`define DPD_ASSERT(label, clk, rst, prop)
`define DPD_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: design/dpd_pkg.sv
// ----------------------------------------------------------------------------
// dpd_pkg
// Types, codes and helpers shared by the debug packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package dpd_pkg;

   // Largest payload length counted before saturation
   localparam int unsigned MAX_PAYLOAD = 256;

   // Fixed field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned EVENT_W  = 2;
   localparam int unsigned LENGTH_W = 9;
   localparam int unsigned NIBBLE_W = 4;

   // Framing characters
   localparam logic [BYTE_W-1:0] CHAR_BREAK = 8'h03;
   localparam logic [BYTE_W-1:0] CHAR_START = 8'h24;  // '$'
   localparam logic [BYTE_W-1:0] CHAR_END   = 8'h23;  // '#'
   localparam logic [BYTE_W-1:0] CASE_BIT   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [BYTE_W-1:0] CHAR_UP_A  = 8'h41;  // 'A'
   localparam logic [BYTE_W-1:0] CHAR_UP_F  = 8'h46;  // 'F'

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_DATA  = 2'd1,
      PH_CK_HI = 2'd2,
      PH_CK_LO = 2'd3
   } phase_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_PAYLOAD = 2'd0,
      EV_BREAK   = 2'd1,
      EV_ACK     = 2'd2,
      EV_NAK     = 2'd3
   } event_type;

   // Decode one checksum character; anything that is not hex reads as zero
   function automatic logic [NIBBLE_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] up;
      logic [BYTE_W-1:0] diff;
      up = c & ~CASE_BIT;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff = c - CHAR_ZERO;
         return diff[NIBBLE_W-1:0];
      end else if (up >= CHAR_UP_A && up <= CHAR_UP_F) begin
         diff = up - CHAR_UP_A + 8'd10;
         return diff[NIBBLE_W-1:0];
      end
      return '0;
   endfunction

endpackage

`default_nettype wire

FILE: design/debug_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// debug_packet_deframer_top
// Receive side of a remote-debug serial link: splits '$'...'#xx' packets.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one received byte per beat (req_rx_byte).
//   rsp channel: zero or one event per byte: a streamed payload byte, a break
//   request (byte 3 between packets), or a verdict (ack on a matching
//   checksum, nak otherwise) carrying the payload length and overflow flag.
//   Bytes between packets other than '$' and byte 3 give no event, nor do
//   '$', '#' and the first checksum digit.
//   Events: an event is registered and appears on rsp in the cycle after its byte is accepted.
//   Throughput: one byte per cycle unless rsp stalls; frame state and event
//   registers are the only storage, with one step of decode logic between.
//   Stall: while an event waits on rsp, req_ready stays high only if the
//   waiting event is taken in the same cycle; otherwise input holds off.
//   Reset: synchronous; returns to waiting for '$' with nothing on rsp.
//   The length counts up to MaxPayload and then sets the overflow flag;
//   rsp_payload_length carries the low 9 bits of the count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "debug_packet_deframer_top_macros.svh"

module debug_packet_deframer_top #(
   parameter int unsigned MaxPayload = dpd_pkg::MAX_PAYLOAD
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [dpd_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [dpd_pkg::EVENT_W-1:0]     rsp_event_res,
   output logic [dpd_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic [dpd_pkg::LENGTH_W-1:0]    rsp_payload_length,
   output logic                            rsp_length_overflow
);

   localparam int unsigned CntW = $clog2(MaxPayload + 1);
   localparam int unsigned ExtW = CntW + dpd_pkg::LENGTH_W;

   // Frame state
   dpd_pkg::phase_type              phase_ff, phase_in;
   logic [dpd_pkg::BYTE_W-1:0]      sum_ff, sum_in;
   logic [dpd_pkg::NIBBLE_W-1:0]    sum_hi_ff, sum_hi_in;
   logic [CntW-1:0]                 count_ff, count_in;
   logic                            ovf_ff, ovf_in;

   // Event register
   logic                            valid_ff, valid_in;
   dpd_pkg::event_type              event_ff, event_in;
   logic [dpd_pkg::BYTE_W-1:0]      byte_ff, byte_in;
   logic [dpd_pkg::LENGTH_W-1:0]    length_ff, length_in;
   logic                            lovf_ff, lovf_in;

   logic                            accept;
   logic                            emit;
   dpd_pkg::event_type              emit_event;
   logic [dpd_pkg::BYTE_W-1:0]      emit_byte;
   logic [ExtW-1:0]                 count_ext;
   logic [dpd_pkg::BYTE_W-1:0]      rx_sum;

   // Take a byte whenever the event register is empty or being drained
   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign count_ext = ExtW'(count_ff);
   assign rx_sum    = {sum_hi_ff, dpd_pkg::hex_value(req_rx_byte)};

   // Advance the frame state and decide the event for this byte
   always_comb begin
      phase_in   = phase_ff;
      sum_in     = sum_ff;
      sum_hi_in  = sum_hi_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      emit       = 1'b0;
      emit_event = dpd_pkg::EV_PAYLOAD;
      emit_byte  = '0;
      if (accept) begin
         unique case (phase_ff)
            dpd_pkg::PH_IDLE: begin
               if (req_rx_byte == dpd_pkg::CHAR_BREAK) begin
                  emit       = 1'b1;
                  emit_event = dpd_pkg::EV_BREAK;
               end else if (req_rx_byte == dpd_pkg::CHAR_START) begin
                  sum_in   = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  phase_in = dpd_pkg::PH_DATA;
               end
            end
            dpd_pkg::PH_DATA: begin
               if (req_rx_byte == dpd_pkg::CHAR_END) begin
                  phase_in = dpd_pkg::PH_CK_HI;
               end else begin
                  sum_in = sum_ff + req_rx_byte;
                  if (count_ff < CntW'(MaxPayload)) begin
                     count_in = count_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  emit      = 1'b1;
                  emit_byte = req_rx_byte;
               end
            end
            dpd_pkg::PH_CK_HI: begin
               sum_hi_in = dpd_pkg::hex_value(req_rx_byte);
               phase_in  = dpd_pkg::PH_CK_LO;
            end
            dpd_pkg::PH_CK_LO: begin
               emit       = 1'b1;
               emit_event = (rx_sum == sum_ff) ? dpd_pkg::EV_ACK : dpd_pkg::EV_NAK;
               phase_in   = dpd_pkg::PH_IDLE;
            end
            default: begin
               phase_in = dpd_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Load a new event, or drop the one just taken
   always_comb begin
      valid_in  = valid_ff;
      event_in  = event_ff;
      byte_in   = byte_ff;
      length_in = length_ff;
      lovf_in   = lovf_ff;
      if (emit) begin
         valid_in = 1'b1;
         event_in = emit_event;
         byte_in  = emit_byte;
         if (emit_event == dpd_pkg::EV_ACK || emit_event == dpd_pkg::EV_NAK) begin
            length_in = count_ext[dpd_pkg::LENGTH_W-1:0];
            lovf_in   = ovf_ff;
         end else begin
            length_in = '0;
            lovf_in   = 1'b0;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= dpd_pkg::PH_IDLE;
         sum_ff    <= '0;
         sum_hi_ff <= '0;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         sum_ff    <= sum_in;
         sum_hi_ff <= sum_hi_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         valid_ff  <= valid_in;
      end
   end

   // Event payload
   always_ff @(posedge clock) begin
      event_ff  <= event_in;
      byte_ff   <= byte_in;
      length_ff <= length_in;
      lovf_ff   <= lovf_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_event_res       = event_ff;
   assign rsp_payload_byte    = byte_ff;
   assign rsp_payload_length  = length_ff;
   assign rsp_length_overflow = lovf_ff;

   // Checks
   `DPD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
   `DPD_ASSERT(a_ovf_saturated, clock, reset, ovf_ff |-> count_ff == CntW'(MaxPayload))
   `DPD_ASSERT(a_data_streams, clock, reset, (accept && phase_ff == dpd_pkg::PH_DATA && req_rx_byte != dpd_pkg::CHAR_END) |=> (rsp_valid && rsp_event_res == dpd_pkg::EV_PAYLOAD))
   `DPD_ASSERT(a_byte_only_payload, clock, reset, (rsp_valid && rsp_event_res != dpd_pkg::EV_PAYLOAD) |-> rsp_payload_byte == '0)
   `DPD_ASSERT(a_ck_lo_verdict, clock, reset, (accept && phase_ff == dpd_pkg::PH_CK_LO) |=> (rsp_valid && (rsp_event_res == dpd_pkg::EV_ACK || rsp_event_res == dpd_pkg::EV_NAK)))

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for debug_packet_deframer_top. Starts with a short
// table of hand-picked bytes, then sends long packets at and past the length limit
// and random streams of packets, breaks and line noise. Every event on the
// rsp channel is checked field by field against a deframer kept in the bench, or against the event of a pinned row.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ITEM_TARGET  = 1250;
   localparam int unsigned CALM_TAIL    = 150;
   localparam int unsigned LATENCY_PAD  = 8;
   localparam int unsigned RUN_LIMIT_NS = 5_000_000;

   typedef struct packed {
      dpd_pkg::event_type                kind;
      logic [dpd_pkg::BYTE_W-1:0]        data;
      logic [dpd_pkg::LENGTH_W-1:0]      length;
      logic                              ovf;
   } deframe_event_type;

   typedef struct packed {
      logic [dpd_pkg::BYTE_W-1:0]        rx;
      logic                              pinned;
      deframe_event_type                 want;
   } stim_row_type;

   typedef enum {MODE_CLEAN, MODE_BAD_SUM, MODE_JUNK_DIGITS, MODE_EARLY_END} pkt_mode_type;

   localparam deframe_event_type NO_PIN = '{dpd_pkg::EV_PAYLOAD, 8'h00, 9'd0, 1'b0};

   // Directed bytes; pinned rows carry the event typed in by hand
   localparam stim_row_type DIRECTED [25] = '{
      // break between packets
      '{dpd_pkg::CHAR_BREAK, 1'b1, '{dpd_pkg::EV_BREAK,   8'h00, 9'd0, 1'b0}},
      // noise, dropped
      '{8'h00,               1'b0, NO_PIN},
      '{8'hFF,               1'b0, NO_PIN},
      // empty packet
      '{dpd_pkg::CHAR_START, 1'b0, NO_PIN},
      '{dpd_pkg::CHAR_END,   1'b0, NO_PIN},
      '{8'h30,               1'b0, NO_PIN},
      '{8'h30,               1'b1, '{dpd_pkg::EV_ACK,     8'h00, 9'd0, 1'b0}},
      // payload extremes
      '{dpd_pkg::CHAR_START, 1'b0, NO_PIN},
      '{8'h00,               1'b1, '{dpd_pkg::EV_PAYLOAD, 8'h00, 9'd0, 1'b0}},
      '{8'hFF,               1'b1, '{dpd_pkg::EV_PAYLOAD, 8'hFF, 9'd0, 1'b0}},
      // break and start inside a packet
      '{dpd_pkg::CHAR_BREAK, 1'b1, '{dpd_pkg::EV_PAYLOAD, 8'h03, 9'd0, 1'b0}},
      '{dpd_pkg::CHAR_START, 1'b1, '{dpd_pkg::EV_PAYLOAD, 8'h24, 9'd0, 1'b0}},
      '{8'hB7,               1'b0, NO_PIN},
      '{dpd_pkg::CHAR_END,   1'b0, NO_PIN},
      // 'd' then 'D'
      '{8'h64,               1'b0, NO_PIN},
      '{8'h44,               1'b1, '{dpd_pkg::EV_ACK,     8'h00, 9'd5, 1'b0}},
      // framing bytes as digits
      '{dpd_pkg::CHAR_START, 1'b0, NO_PIN},
      '{dpd_pkg::CHAR_END,   1'b0, NO_PIN},
      '{dpd_pkg::CHAR_END,   1'b0, NO_PIN},
      '{dpd_pkg::CHAR_START, 1'b1, '{dpd_pkg::EV_ACK,     8'h00, 9'd0, 1'b0}},
      // non-hex digit, bad sum
      '{dpd_pkg::CHAR_START, 1'b0, NO_PIN},
      '{8'h41,               1'b0, NO_PIN},
      '{dpd_pkg::CHAR_END,   1'b0, NO_PIN},
      '{8'h47,               1'b0, NO_PIN},
      '{8'h31,               1'b1, '{dpd_pkg::EV_NAK,     8'h00, 9'd1, 1'b0}}
   };

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [dpd_pkg::BYTE_W-1:0]         req_rx_byte;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [dpd_pkg::EVENT_W-1:0]        rsp_event_res;
   logic [dpd_pkg::BYTE_W-1:0]         rsp_payload_byte;
   logic [dpd_pkg::LENGTH_W-1:0]       rsp_payload_length;
   logic                               rsp_length_overflow;

   // Bench copy of the frame state
   dpd_pkg::phase_type                 frm_phase = dpd_pkg::PH_IDLE;
   logic [dpd_pkg::BYTE_W-1:0]         frm_sum   = '0;
   logic [dpd_pkg::NIBBLE_W-1:0]       frm_hi    = '0;
   int unsigned                        frm_count = 0;
   logic                               frm_ovf   = 1'b0;

   deframe_event_type     pending_events [$];
   deframe_event_type     expected_head;

   bit                    send_gaps   = 1'b1;
   bit                    recv_stalls = 1'b1;
   int unsigned           stall_left  = 0;
   int unsigned           item_count  = 0;
   int unsigned           fail_count  = 0;
   int unsigned           break_count = 0;
   int unsigned           ack_count   = 0;
   int unsigned           nak_count   = 0;
   int unsigned           ovf_count   = 0;
   int unsigned           beat_count  = 0;

   debug_packet_deframer_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_res       (rsp_event_res),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_length_overflow (rsp_length_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Checksum digit value; anything outside 0-9, a-f, A-F reads as zero
   function automatic logic [dpd_pkg::NIBBLE_W-1:0] digit_value(
         input logic [dpd_pkg::BYTE_W-1:0] c);
      logic [dpd_pkg::BYTE_W-1:0] folded;
      folded = c | 8'h20;
      if (c >= 8'h30 && c <= 8'h39) return c[3:0];
      if (folded >= 8'h61 && folded <= 8'h66) return folded[3:0] + 4'd9;
      return 4'd0;
   endfunction

   function automatic logic [dpd_pkg::BYTE_W-1:0] hex_char(
         input logic [dpd_pkg::NIBBLE_W-1:0] nib, input bit upper);
      if (nib < 4'd10) return 8'h30 + nib;
      return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
   endfunction

   // Advance the bench deframer by one byte; return 1 when an event is due
   function automatic bit deframe_step(input logic [dpd_pkg::BYTE_W-1:0] c,
                                       output deframe_event_type ev);
      logic [dpd_pkg::BYTE_W-1:0] claimed;
      ev = NO_PIN;
      case (frm_phase)
         dpd_pkg::PH_IDLE: begin
            if (c == dpd_pkg::CHAR_BREAK) begin
               ev.kind = dpd_pkg::EV_BREAK;
               return 1'b1;
            end
            if (c == dpd_pkg::CHAR_START) begin
               frm_sum   = '0;
               frm_count = 0;
               frm_ovf   = 1'b0;
               frm_phase = dpd_pkg::PH_DATA;
            end
            return 1'b0;
         end
         dpd_pkg::PH_DATA: begin
            if (c == dpd_pkg::CHAR_END) begin
               frm_phase = dpd_pkg::PH_CK_HI;
               return 1'b0;
            end
            frm_sum = frm_sum + c;
            // saturate the count, keep summing and streaming
            if (frm_count < dpd_pkg::MAX_PAYLOAD) frm_count++;
            else frm_ovf = 1'b1;
            ev.data = c;
            return 1'b1;
         end
         dpd_pkg::PH_CK_HI: begin
            frm_hi    = digit_value(c);
            frm_phase = dpd_pkg::PH_CK_LO;
            return 1'b0;
         end
         default: begin
            claimed   = {frm_hi, digit_value(c)};
            frm_phase = dpd_pkg::PH_IDLE;
            ev.kind   = (claimed == frm_sum) ? dpd_pkg::EV_ACK : dpd_pkg::EV_NAK;
            ev.length = 9'(frm_count);
            ev.ovf    = frm_ovf;
            return 1'b1;
         end
      endcase
   endfunction

   // Drive one beat from a falling edge and wait for it to be taken
   task automatic send_byte(input logic [dpd_pkg::BYTE_W-1:0] b, input logic pinned,
                            input deframe_event_type want);
      deframe_event_type got;
      bit                produced;
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (frm_phase != dpd_pkg::PH_IDLE || b == dpd_pkg::CHAR_BREAK ||
          b == dpd_pkg::CHAR_START) item_count++;
      produced = deframe_step(b, got);
      if (pinned) pending_events.push_back(want);
      else if (produced) pending_events.push_back(got);
      @(negedge clock);
   endtask

   // Hold the sender until every outstanding event has come out
   task automatic drain_events();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_events.size() != 0);
   endtask

   task automatic send_frame(input int unsigned len, input pkt_mode_type mode);
      logic [dpd_pkg::BYTE_W-1:0] sum;
      logic [dpd_pkg::BYTE_W-1:0] b;
      logic [dpd_pkg::BYTE_W-1:0] ck;
      int unsigned                k;
      sum = '0;
      send_byte(dpd_pkg::CHAR_START, 1'b0, NO_PIN);
      for (k = 0; k < len; k++) begin
         case ($urandom_range(0, 15))
            0:       b = dpd_pkg::CHAR_START;
            1:       b = dpd_pkg::CHAR_BREAK;
            2:       b = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            default: b = 8'($urandom_range(0, 255));
         endcase
         // keep the frame open unless this packet is meant to end early
         if (b == dpd_pkg::CHAR_END && mode != MODE_EARLY_END) b = ~dpd_pkg::CHAR_END;
         sum = sum + b;
         send_byte(b, 1'b0, NO_PIN);
      end
      send_byte(dpd_pkg::CHAR_END, 1'b0, NO_PIN);
      if (mode == MODE_JUNK_DIGITS) begin
         send_byte(8'($urandom_range(0, 255)), 1'b0, NO_PIN);
         send_byte(8'($urandom_range(0, 255)), 1'b0, NO_PIN);
      end else begin
         ck = (mode == MODE_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
         send_byte(hex_char(ck[7:4], 1'($urandom_range(0, 1))), 1'b0, NO_PIN);
         send_byte(hex_char(ck[3:0], 1'($urandom_range(0, 1))), 1'b0, NO_PIN);
      end
   endtask

   // Receiver: stall in bursts while allowed
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(1, 7) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Check each event beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            $error("rsp_event_res: no event expected, got %0d", rsp_event_res);
            fail_count++;
         end else begin
            expected_head = pending_events.pop_front();
            if (rsp_event_res !== expected_head.kind) begin
               $error("rsp_event_res: expected %0d, got %0d",
                      expected_head.kind, rsp_event_res);
               fail_count++;
            end
            if (rsp_payload_byte !== expected_head.data) begin
               $error("rsp_payload_byte: expected %0h, got %0h",
                      expected_head.data, rsp_payload_byte);
               fail_count++;
            end
            if (rsp_payload_length !== expected_head.length) begin
               $error("rsp_payload_length: expected %0d, got %0d",
                      expected_head.length, rsp_payload_length);
               fail_count++;
            end
            if (rsp_length_overflow !== expected_head.ovf) begin
               $error("rsp_length_overflow: expected %0b, got %0b",
                      expected_head.ovf, rsp_length_overflow);
               fail_count++;
            end
            case (expected_head.kind)
               dpd_pkg::EV_PAYLOAD: beat_count++;
               dpd_pkg::EV_BREAK:   break_count++;
               dpd_pkg::EV_ACK:     ack_count++;
               default:             nak_count++;
            endcase
            if (expected_head.ovf) ovf_count++;
         end
      end
   end

   // Stimulus
   initial begin
      int unsigned  r;
      int unsigned  len;
      int unsigned  row;
      bit           paused_mid;
      pkt_mode_type mode;
      paused_mid  = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < 25; row++)
         send_byte(DIRECTED[row].rx, DIRECTED[row].pinned, DIRECTED[row].want);
      drain_events();

      // right at the length limit, then just past it
      send_frame(dpd_pkg::MAX_PAYLOAD, MODE_CLEAN);
      send_frame(dpd_pkg::MAX_PAYLOAD + 2, MODE_CLEAN);

      while (item_count < ITEM_TARGET) begin
         if (item_count >= ITEM_TARGET - CALM_TAIL) begin
            send_gaps   = 1'b0;
            recv_stalls = 1'b0;
         end else begin
            send_gaps   = $urandom_range(0, 3) != 0;
            recv_stalls = $urandom_range(0, 3) != 0;
         end
         // line noise between packets
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
               send_byte(($urandom_range(0, 3) == 0) ? dpd_pkg::CHAR_BREAK :
                         8'($urandom_range(0, 255)), 1'b0, NO_PIN);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         r   = $urandom_range(0, 9);
         if (r < 7) mode = MODE_CLEAN;
         else if (r == 7) mode = MODE_BAD_SUM;
         else if (r == 8) mode = MODE_JUNK_DIGITS;
         else mode = MODE_EARLY_END;
         send_frame(len, mode);
         if (!paused_mid && item_count >= ITEM_TARGET / 2) begin
            drain_events();
            paused_mid = 1'b1;
         end
      end

      drain_events();
      repeat (LATENCY_PAD) @(negedge clock);
      $display("Covered %0d framed bytes: %0d ack, %0d nak, %0d over the length limit",
               item_count, ack_count, nak_count, ovf_count);
      $display("Checked %0d payload beats and %0d break events", beat_count, break_count);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #RUN_LIMIT_NS;
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/dpd_pkg.sv
design/debug_packet_deframer_top.sv
bench/tb.sv
